@@ rtl/core/mnhs_pkg.sv @@
`default_nettype none
package mnhs_pkg;

	localparam int DEF_NUM_SLOTS = 16;

	// port widths
	localparam int IN_DATA_W  = 176;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 3;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam int HASH_BYTES = 16;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_NODE_ID   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_PER_FLOW  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_PID = 2'd2;

	// result status codes
	localparam logic [2:0] STS_ROUTE  = 3'd0;
	localparam logic [2:0] STS_HASH   = 3'd1;
	localparam logic [2:0] STS_RR     = 3'd2;
	localparam logic [2:0] STS_EMPTY  = 3'd3;
	localparam logic [2:0] STS_REJECT = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISP,
		ST_SCAN,
		ST_PICK,
		ST_HASH,
		ST_OUT
	} ctl_state_t;

	typedef enum logic [2:0] {
		HS_IDLE,
		HS_FOLD,
		HS_PRIO,
		HS_DIV,
		HS_DONE
	} hash_state_t;

	typedef struct packed {
		logic start;
		logic add_prio;
	} hash_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} hash_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/mnhs_ram.sv @@
`default_nettype none
module mnhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/mnhs_hash.sv @@
`default_nettype none
module mnhs_hash #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire mnhs_pkg::hash_ctl_t            ctl,
	input  wire logic [31:0]                    node_id,
	input  wire logic [31:0]                    src_addr,
	input  wire logic [31:0]                    dst_addr,
	input  wire logic [31:0]                    flow_id,
	input  wire logic [31:0]                    priority_req,
	input  wire logic [$clog2(NUM_SLOTS+1)-1:0] count,
	output mnhs_pkg::hash_stat_t                stat,
	output logic      [$clog2(NUM_SLOTS)-1:0]   rem
);
	import mnhs_pkg::*;

	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int IW = $clog2(NUM_SLOTS);
	localparam logic [4:0] FOLD_LAST = 5'(HASH_BYTES - 1);
	localparam logic [4:0] DIV_LAST  = 5'd31;

	hash_state_t hs_q, hs_d;
	logic [127:0]  bytes_q;
	logic [31:0]   h_q;
	logic [31:0]   prio_q;
	logic          addp_q;
	logic [4:0]    step_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] div_q;
	logic [CW:0]   trial;
	logic [CW:0]   diff;

	// one restoring division step; top bit of diff set means trial < divisor
	assign trial = {rem_q, h_q[31]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= HS_IDLE;
		end else begin
			hs_q <= hs_d;
		end
	end

	always_comb begin
		hs_d = hs_q;
		case (hs_q)
			HS_IDLE: begin
				if (ctl.start) hs_d = HS_FOLD;
			end
			HS_FOLD: begin
				if (step_q == FOLD_LAST) hs_d = HS_PRIO;
			end
			HS_PRIO: hs_d = HS_DIV;
			HS_DIV: begin
				if (step_q == DIV_LAST) hs_d = HS_DONE;
			end
			HS_DONE: hs_d = HS_IDLE;
			default: hs_d = HS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (hs_q)
			HS_IDLE: begin
				bytes_q <= {flow_id, dst_addr, src_addr, node_id};
				prio_q  <= priority_req;
				addp_q  <= ctl.add_prio;
				div_q   <= count;
				h_q     <= '0;
				step_q  <= '0;
			end
			HS_FOLD: begin
				h_q     <= (h_q << 3) + h_q + {{24{bytes_q[7]}}, bytes_q[7:0]};
				bytes_q <= bytes_q >> 8;
				step_q  <= (step_q == FOLD_LAST) ? 5'd0 : step_q + 5'd1;
			end
			HS_PRIO: begin
				if (addp_q) h_q <= h_q + prio_q;
				rem_q <= '0;
			end
			HS_DIV: begin
				rem_q  <= diff[CW] ? trial[CW-1:0] : diff[CW-1:0];
				h_q    <= h_q << 1;
				step_q <= step_q + 5'd1;
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (hs_q != HS_IDLE);
	assign stat.done = (hs_q == HS_DONE);
	assign rem       = rem_q[IW-1:0];

endmodule
`default_nettype wire

@@ rtl/core/multipath_next_hop_select.sv @@
`default_nettype none
// Multipath next-hop selector. Install items (tuser bit 0 set) append a node id
// to the slot table; classify items pick an output slot by source-routed path
// word, by flow hash, or by round robin. One item is in work at a time and its
// result sits in an output register, so the next item is taken while that
// result waits. A source-route search makes one pass over the slot table
// through its single read port; the flow hash takes 16 byte folds, a priority
// add, a 32-step restoring modulo and a done state. A result held in the
// output register by a low m_tready stalls the next result as long.
// The hop table is a RAM with no reset: only installed entries are ever read.
module multipath_next_hop_select #(
	parameter int NUM_SLOTS = mnhs_pkg::DEF_NUM_SLOTS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [mnhs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [mnhs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// path_word[31:0] src_addr[63:32] dst_addr[95:64] flow_id[127:96]
	// priority_req[159:128] next_node[168:160] zero pad[175:169]
	input  wire logic [mnhs_pkg::IN_DATA_W-1:0]    s_tdata,
	// func[0] src_route[1]
	input  wire logic [mnhs_pkg::IN_USER_W-1:0]    s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// slot[3:0] path_out[35:4] zero pad[39:36]
	output logic      [mnhs_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status[2:0]
	output logic      [mnhs_pkg::OUT_USER_W-1:0]   m_tuser
);
	import mnhs_pkg::*;

	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int IW = $clog2(NUM_SLOTS);
	localparam logic [CW-1:0] FULL = CW'(NUM_SLOTS);

	ctl_state_t st_q, st_d;

	// configuration
	logic [31:0] node_id_q;
	logic        per_flow_q;
	logic        check_pid_q;

	// item under work
	logic        func_q;
	logic        pen_q;
	logic [31:0] path_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [31:0] flow_q;
	logic [31:0] prio_q;
	logic [8:0]  nn_q;

	logic [CW-1:0] cnt_q;
	logic [IW-1:0] rr_q;

	// table scan
	logic [CW-1:0] rd_q;
	logic          issue;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic [3:0]    hit_q;
	logic [IW-1:0] hit_slot_q [4];
	logic [1:0]    sel;
	logic [7:0]    rdata;
	logic          scan_last;

	// staged result and output register
	logic [IW-1:0] res_slot_q, res_slot_d;
	logic [31:0]   res_path_q, res_path_d;
	logic [2:0]    res_sts_q, res_sts_d;
	logic          m_valid_q;
	logic [3:0]    m_slot_q;
	logic [31:0]   m_path_q;
	logic [2:0]    m_sts_q;
	logic [IW+3:0] slot_ext;

	logic       res_ld, ram_we, cnt_inc, rr_adv, scan_start, fallback, out_ld;
	hash_ctl_t  hctl;
	hash_stat_t hstat;
	logic [IW-1:0] hrem;

	assign s_tready  = (st_q == ST_IDLE);
	assign issue     = (rd_q < cnt_q);
	assign scan_last = vld_s1 && (CW'(idx_s1) == cnt_q - CW'(1));

	mnhs_ram #(
		.WIDTH(8),
		.DEPTH(NUM_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[IW-1:0]),
		.wdata(nn_q[7:0]),
		.raddr(rd_q[IW-1:0]),
		.rdata(rdata)
	);

	mnhs_hash #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_hash (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (hctl),
		.node_id     (node_id_q),
		.src_addr    (src_q),
		.dst_addr    (dst_q),
		.flow_id     (flow_q),
		.priority_req(prio_q),
		.count       (cnt_q),
		.stat        (hstat),
		.rem         (hrem)
	);

	// highest path byte with a match wins
	always_comb begin
		sel = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (hit_q[i]) sel = 2'(i);
		end
	end

	always_comb begin
		st_d       = st_q;
		res_ld     = 1'b0;
		res_slot_d = '0;
		res_path_d = path_q;
		res_sts_d  = STS_ROUTE;
		ram_we     = 1'b0;
		cnt_inc    = 1'b0;
		rr_adv     = 1'b0;
		scan_start = 1'b0;
		fallback   = 1'b0;
		out_ld     = 1'b0;
		hctl       = '0;
		case (st_q)
			ST_IDLE: begin
				if (s_tvalid) st_d = ST_DISP;
			end
			ST_DISP: begin
				if (func_q) begin
					res_ld     = 1'b1;
					res_path_d = '0;
					st_d       = ST_OUT;
					if (nn_q[8] || cnt_q == FULL) begin
						res_sts_d = STS_REJECT;
					end else begin
						ram_we     = 1'b1;
						cnt_inc    = 1'b1;
						res_slot_d = cnt_q[IW-1:0];
					end
				end else if (cnt_q == '0) begin
					res_ld    = 1'b1;
					res_sts_d = STS_EMPTY;
					st_d      = ST_OUT;
				end else if (pen_q && cnt_q >= CW'(2)) begin
					scan_start = 1'b1;
					st_d       = ST_SCAN;
				end else begin
					fallback = 1'b1;
				end
			end
			ST_SCAN: begin
				if (scan_last) st_d = ST_PICK;
			end
			ST_PICK: begin
				if (|hit_q) begin
					res_ld     = 1'b1;
					res_slot_d = hit_slot_q[sel];
					res_path_d = path_q | (32'h80 << {sel, 3'b000});
					st_d       = ST_OUT;
				end else begin
					fallback = 1'b1;
				end
			end
			ST_HASH: begin
				if (hstat.done) begin
					res_ld     = 1'b1;
					res_slot_d = hrem;
					res_sts_d  = STS_HASH;
					st_d       = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_valid_q || m_tready) begin
					out_ld = 1'b1;
					st_d   = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
		if (fallback) begin
			if (per_flow_q || check_pid_q) begin
				hctl.start    = 1'b1;
				hctl.add_prio = check_pid_q;
				st_d          = ST_HASH;
			end else begin
				res_ld     = 1'b1;
				res_slot_d = rr_q;
				res_sts_d  = STS_RR;
				rr_adv     = 1'b1;
				st_d       = ST_OUT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			node_id_q   <= '0;
			per_flow_q  <= 1'b0;
			check_pid_q <= 1'b0;
			cnt_q       <= '0;
			rr_q        <= '0;
			vld_s1      <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_addr)
					CFG_NODE_ID:   node_id_q   <= cfg_wdata;
					CFG_PER_FLOW:  per_flow_q  <= cfg_wdata[0];
					CFG_CHECK_PID: check_pid_q <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			if (cnt_inc) cnt_q <= cnt_q + CW'(1);
			// pointer stays below the slot count once the table is non-empty
			if (rr_adv) rr_q <= (CW'(rr_q) == cnt_q - CW'(1)) ? '0 : rr_q + IW'(1);
			vld_s1 <= (st_q == ST_SCAN) && issue;
			if (out_ld) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tuser[0];
			pen_q  <= s_tuser[1];
			path_q <= s_tdata[31:0];
			src_q  <= s_tdata[63:32];
			dst_q  <= s_tdata[95:64];
			flow_q <= s_tdata[127:96];
			prio_q <= s_tdata[159:128];
			nn_q   <= s_tdata[168:160];
		end
		if (scan_start) begin
			rd_q  <= '0;
			hit_q <= '0;
		end else if (st_q == ST_SCAN) begin
			if (issue) rd_q <= rd_q + CW'(1);
		end
		idx_s1 <= rd_q[IW-1:0];
		// first (lowest) slot matching each unused path byte
		if (vld_s1 && st_q == ST_SCAN) begin
			for (int i = 0; i < 4; i++) begin
				if (!path_q[8*i+7] && !hit_q[i] && rdata == path_q[8*i +: 8]) begin
					hit_q[i]      <= 1'b1;
					hit_slot_q[i] <= idx_s1;
				end
			end
		end
		if (res_ld) begin
			res_slot_q <= res_slot_d;
			res_path_q <= res_path_d;
			res_sts_q  <= res_sts_d;
		end
		if (out_ld) begin
			m_slot_q <= slot_ext[3:0];
			m_path_q <= res_path_q;
			m_sts_q  <= res_sts_q;
		end
	end

	assign slot_ext = {4'b0000, res_slot_q};
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, m_path_q, m_slot_q};
	assign m_tuser  = m_sts_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("slot count beyond table depth");

	a_rr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (CW'(rr_q) < cnt_q))
		else $error("round-robin pointer past slot count");

	a_hash_done: assert property (@(posedge clk) disable iff (!arst_n)
		hstat.done |-> (st_q == ST_HASH))
		else $error("hash finished outside hash wait");

	a_hash_rem: assert property (@(posedge clk) disable iff (!arst_n)
		hstat.done |-> (CW'(hrem) < cnt_q))
		else $error("hash slot not below slot count");

	a_hash_start: assert property (@(posedge clk) disable iff (!arst_n)
		hctl.start |-> !hstat.busy)
		else $error("hash started while busy");

	a_install_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("install write without count step");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import mnhs_pkg::*;

	localparam int SLOTS = DEF_NUM_SLOTS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// path_word, src_addr, dst_addr, flow_id, priority_req, next_node, pad
	logic [IN_DATA_W-1:0] s_tdata = '0;
	// func, src_route
	logic [IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// slot, path_out, pad
	logic [OUT_DATA_W-1:0] m_tdata;
	// status
	logic [OUT_USER_W-1:0] m_tuser;

	multipath_next_hop_select dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic [3:0]  slot;
		logic [31:0] path_out;
		logic [2:0]  status;
	} hop_result_t;

	// shadow of the block's registers and state
	logic [31:0] node_id_q;
	logic        per_flow_q, check_pid_q;
	logic [7:0]  hop_ids [SLOTS];
	int          installed;
	int          rr_pos;

	hop_result_t pending_q[$];
	int errors = 0;
	int burst_left = 0;

	// h = h*9 + sign-extended byte, low byte first
	function automatic logic [31:0] fold_bytes(logic [31:0] h, logic [31:0] w);
		logic [31:0] b;
		for (int k = 0; k < 4; k++) begin
			b = {{24{w[8*k+7]}}, w[8*k +: 8]};
			h = h * 32'd9 + b;
		end
		return h;
	endfunction

	function automatic hop_result_t select_next_hop(logic func, logic path_en,
			logic [31:0] path_word, logic [31:0] src, logic [31:0] dst,
			logic [31:0] flow, logic [31:0] prio, logic [8:0] node);
		hop_result_t r;
		logic found;
		logic [7:0] b;
		logic [31:0] h;
		r = '0;
		found = 1'b0;
		if (func) begin
			if (node[8] || installed >= SLOTS) begin
				r.status = STS_REJECT;
			end else begin
				hop_ids[installed] = node[7:0];
				r.slot = installed[3:0];
				r.status = STS_ROUTE;
				installed++;
			end
			return r;
		end
		r.path_out = path_word;
		if (installed == 0) begin
			r.status = STS_EMPTY;
			return r;
		end
		if (path_en && installed >= 2) begin
			for (int i = 3; i >= 0 && !found; i--) begin
				b = path_word[8*i +: 8];
				if (!b[7]) begin
					for (int j = 0; j < installed && !found; j++) begin
						if (hop_ids[j] == b) begin
							r.slot = j[3:0];
							r.path_out = path_word | (32'h80 << (8 * i));
							r.status = STS_ROUTE;
							found = 1'b1;
						end
					end
				end
			end
		end
		if (!found) begin
			if (per_flow_q || check_pid_q) begin
				h = fold_bytes(32'd0, node_id_q);
				h = fold_bytes(h, src);
				h = fold_bytes(h, dst);
				h = fold_bytes(h, flow);
				if (check_pid_q)
					h = h + prio;
				r.slot = 4'(h % installed);
				r.status = STS_HASH;
			end else begin
				r.slot = 4'(rr_pos % installed);
				rr_pos = (rr_pos % installed + 1) % installed;
				r.status = STS_RR;
			end
		end
		return r;
	endfunction

	// one transfer into the block; bursts with random gaps
	task automatic send_item(logic func, logic path_en, logic [31:0] path_word,
			logic [31:0] src, logic [31:0] dst, logic [31:0] flow,
			logic [31:0] prio, logic [8:0] node);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= {path_en, func};
		s_tdata <= {7'd0, node, prio, flow, dst, src, path_word};
		pending_q.push_back(select_next_hop(func, path_en, path_word, src, dst,
			flow, prio, node));
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		// nothing is left in flight here unless the guard ran out
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_NODE_ID:   node_id_q = val;
			CFG_PER_FLOW:  per_flow_q = val[0];
			CFG_CHECK_PID: check_pid_q = val[0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_path();
		logic [31:0] p;
		// bias bytes toward installed ids so searches hit
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 3))
				0: p[8*i +: 8] = 8'($urandom);
				1: p[8*i +: 8] = installed ? hop_ids[$urandom_range(0, installed - 1)]
					: 8'($urandom);
				2: p[8*i +: 8] = installed ? (hop_ids[$urandom_range(0, installed - 1)]
					| 8'h80) : 8'($urandom);
				default: p[8*i +: 8] = 8'($urandom_range(0, 15));
			endcase
		end
		return p;
	endfunction

	task automatic classify_random(int n);
		for (int i = 0; i < n; i++)
			send_item(1'b0, 1'($urandom), rand_path(), $urandom, $urandom,
				$urandom, $urandom, 9'($urandom));
	endtask

	task automatic install_node(logic [8:0] node);
		send_item(1'b1, 1'($urandom), $urandom, $urandom, $urandom, $urandom,
			$urandom, node);
	endtask

	// empty table, rejects, table edges, source-route cases
	task automatic test_directed();
		send_item(1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 9'h0);
		send_item(1'b0, 1'b1, 32'hFFFF_FFFF, '1, '1, '1, '1, 9'h1FF);
		install_node(9'h1FF);   // -1 rejected
		install_node(9'h100);   // most negative rejected
		install_node(9'h0);
		// one slot: path word ignored, round robin
		send_item(1'b0, 1'b1, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 9'h0);
		install_node(9'h0FF);
		install_node(9'h07F);
		install_node(9'h012);
		// top byte hit, used byte skipped, lower byte hit, no hit
		send_item(1'b0, 1'b1, 32'h7F00_0000, '0, '0, '0, '0, 9'h0);
		send_item(1'b0, 1'b1, 32'hFF12_0000, '0, '0, '0, '0, 9'h0);
		send_item(1'b0, 1'b1, 32'h8080_8000, '0, '0, '0, '0, 9'h0);
		send_item(1'b0, 1'b1, 32'h5555_5555, '1, '1, '1, '1, 9'h0);
		send_item(1'b0, 1'b0, 32'h7F7F_7F7F, '0, '0, '0, '0, 9'h0);
		for (int i = 0; i < 4; i++)
			send_item(1'b0, 1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, 9'h0);
		wait_drained();
	endtask

	task automatic test_modes();
		logic [1:0] mode;
		for (int phase = 0; phase < 10; phase++) begin
			mode = 2'(phase);
			write_reg(CFG_NODE_ID, (phase == 1) ? 32'hFFFF_FFFF : (phase == 2) ? 32'h0
				: $urandom);
			write_reg(CFG_PER_FLOW, 32'(mode[0]));
			write_reg(CFG_CHECK_PID, 32'(mode[1]));
			for (int k = 0; k < 4 && installed < SLOTS + 1; k++)
				install_node(($urandom_range(0, 5) == 0) ? 9'h1FF : 9'($urandom_range(0, 255)));
			classify_random(60);
			wait_drained();
		end
		// full table rejects
		while (installed < SLOTS)
			install_node(9'($urandom_range(0, 255)));
		install_node(9'h055);
		install_node(9'h000);
		classify_random(20);
		wait_drained();
	endtask

	// result checker with its own stall pattern
	always @(posedge clk) begin
		hop_result_t got, exp;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[3:0], m_tdata[35:4], m_tuser};
			if (pending_q.size() == 0) begin
				$display("%0t unexpected result slot=%0d path=%h status=%0d", $time,
					got.slot, got.path_out, got.status);
				errors++;
			end else begin
				exp = pending_q.pop_front();
				if (got.slot !== exp.slot) begin
					$display("%0t slot exp %0d got %0d", $time, exp.slot, got.slot);
					errors++;
				end
				if (got.path_out !== exp.path_out) begin
					$display("%0t path_out exp %h got %h", $time, exp.path_out, got.path_out);
					errors++;
				end
				if (got.status !== exp.status) begin
					$display("%0t status exp %0d got %0d", $time, exp.status, got.status);
					errors++;
				end
			end
		end
		m_tready <= ($time / 2000) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
	end

	initial begin
		node_id_q = '0;
		per_flow_q = 1'b0;
		check_pid_q = 1'b0;
		installed = 0;
		rr_pos = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_modes();
		wait_drained();
		if (errors == 0 && pending_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
